/* design/wsmm_pkg.sv */
// ----------------------------------------------------------------------------
// wsmm_pkg
// Shared sizes, register indexes and types of the weight-stationary
// matrix multiplier.
// ----------------------------------------------------------------------------
package wsmm_pkg;

    // store geometry
    localparam int MAX_INNER = 64;
    localparam int MAX_COLS  = 16;

    // derived widths
    localparam int K_W   = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int LEN_W = $clog2(MAX_INNER + 1);
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int SEL_W = (COL_W > 4) ? COL_W : 4;

    // arithmetic widths
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 38;
    localparam int OUT_W  = 32;

    // configuration register indexes
    localparam logic [0:0] CFG_INNER_LEN = 1'd0;
    localparam logic [0:0] CFG_OUT_COLS  = 1'd1;

    // reset values of the configuration registers
    localparam logic [6:0] INNER_LEN_RST = 7'd64;
    localparam logic [4:0] OUT_COLS_RST  = 5'd16;

    // one item travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic               is_load;
        logic [5:0]         k;
        logic [3:0]         col;
        logic signed [15:0] value;
        logic               clear;
        logic               fire;
    } token_t;

    // what a cell reports to the drain logic
    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] sum;
    } cell_status_t;

endpackage

/* design/weight_stationary_matmul_top.sv */
// ----------------------------------------------------------------------------
// weight_stationary_matmul_top
// Streaming matrix multiply against a stored right matrix, one cell per
// right-matrix column.
// ----------------------------------------------------------------------------
// Load beats and activation beats enter one per cycle while intake is open
// and walk down a chain of MAX_COLS column cells, each registering the beat
// onward; each cell reads its weight, multiplies and accumulates over three
// stages. The beat at the last inner position closes a row: intake stops
// while that beat reaches the chain's end and until the last of the out_cols
// result beats is staged, longer if out_ready is held low. Weights are not
// cleared at reset; an activation must only use positions already loaded.
// ----------------------------------------------------------------------------
module weight_stationary_matmul_top
    import wsmm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    // input beats
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [5:0]         k_position,
    input  logic [3:0]         col_select,
    input  logic signed [15:0] in_value,
    // result beats
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         out_col,
    output logic signed [31:0] out_value,
    output logic               out_saturated,
    output logic               out_last
);

    logic [6:0]              inner_len_reg;
    logic [4:0]              out_cols_reg;
    logic [LEN_W-1:0]        len_eff;
    logic [CNT_W-1:0]        cols_eff;
    logic                    in_fire;
    logic                    load_ok;
    logic                    act_ok;
    logic                    is_fire;
    token_t                  entry_tok;
    token_t                  link [MAX_COLS];
    cell_status_t            status [MAX_COLS];
    logic                    busy_reg;
    logic                    drain_reg;
    logic [COL_W-1:0]        col_cnt_reg;
    logic                    out_load;
    logic                    cnt_last;
    logic signed [ACC_W-1:0] sel_sum;
    logic signed [OUT_W-1:0] sel_value;
    logic                    sel_sat;
    logic                    out_valid_reg;
    logic [3:0]              out_col_reg;
    logic signed [OUT_W-1:0] out_value_reg;
    logic                    out_sat_reg;
    logic                    out_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_len_reg <= INNER_LEN_RST;
            out_cols_reg  <= OUT_COLS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INNER_LEN: inner_len_reg <= cfg_wdata;
                CFG_OUT_COLS:  out_cols_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // effective sizes, clamped to the store
    always_comb
    begin
        if (inner_len_reg == 7'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(inner_len_reg) > MAX_INNER)
        begin
            len_eff = LEN_W'(MAX_INNER);
        end
        else
        begin
            len_eff = LEN_W'(inner_len_reg);
        end
        if (out_cols_reg == 5'd0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (32'(out_cols_reg) > MAX_COLS)
        begin
            cols_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNT_W'(out_cols_reg);
        end
    end

    // entry beat
    assign in_ready = !busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign load_ok  = (32'(k_position) < MAX_INNER) && (32'(col_select) < MAX_COLS);
    assign act_ok   = 32'(k_position) < 32'(len_eff);
    assign is_fire  = 32'(k_position) == (32'(len_eff) - 32'd1);

    assign entry_tok.valid   = in_fire && (req_type ? act_ok : load_ok);
    assign entry_tok.is_load = !req_type;
    assign entry_tok.k       = k_position;
    assign entry_tok.col     = col_select;
    assign entry_tok.value   = in_value;
    assign entry_tok.clear   = k_position == 6'd0;
    assign entry_tok.fire    = is_fire;

    assign link[0] = entry_tok;

    // column cell chain
    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        if (i < MAX_COLS - 1)
        begin : g_mid
            wsmm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .col_id   (COL_W'(i)),
                .cols_eff (cols_eff),
                .tok_in   (link[i]),
                .tok_out  (link[i+1]),
                .status   (status[i])
            );
        end
        else
        begin : g_end
            wsmm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .col_id   (COL_W'(i)),
                .cols_eff (cols_eff),
                .tok_in   (link[i]),
                .tok_out  (),
                .status   (status[i])
            );
        end
    end

    // result selection and clipping to q16.16
    assign sel_sum  = status[col_cnt_reg].sum;
    assign cnt_last = CNT_W'(col_cnt_reg) == (cols_eff - CNT_W'(1));
    assign out_load = drain_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (sel_sum[ACC_W-1:OUT_W-1] == '0 || sel_sum[ACC_W-1:OUT_W-1] == '1)
        begin
            sel_value = sel_sum[OUT_W-1:0];
            sel_sat   = 1'b0;
        end
        else
        begin
            sel_value = sel_sum[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            sel_sat   = 1'b1;
        end
    end

    // row control: hold intake from the closing beat until the last result is staged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            drain_reg   <= 1'b0;
            col_cnt_reg <= '0;
        end
        else
        begin
            if (entry_tok.valid && !entry_tok.is_load && entry_tok.fire)
            begin
                busy_reg <= 1'b1;
            end
            if (status[MAX_COLS-1].done)
            begin
                drain_reg <= 1'b1;
            end
            if (out_load)
            begin
                if (cnt_last)
                begin
                    drain_reg   <= 1'b0;
                    busy_reg    <= 1'b0;
                    col_cnt_reg <= '0;
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + COL_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg   <= 4'(col_cnt_reg);
            out_value_reg <= sel_value;
            out_sat_reg   <= sel_sat;
            out_last_reg  <= cnt_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_col       = out_col_reg;
    assign out_value     = out_value_reg;
    assign out_saturated = out_sat_reg;
    assign out_last      = out_last_reg;

endmodule

/* design/wsmm_ram.sv */
// ----------------------------------------------------------------------------
// wsmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wsmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/wsmm_cell.sv */
// ----------------------------------------------------------------------------
// wsmm_cell
// One column of the multiplier: holds that column's weights and its
// accumulator, forwards every beat to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module wsmm_cell
    import wsmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [COL_W-1:0] col_id,
    input  logic [CNT_W-1:0] cols_eff,
    input  token_t           tok_in,
    output token_t           tok_out,
    output cell_status_t     status
);

    token_t                   tok_reg;
    logic [DATA_W-1:0]        weight;
    logic                     wr_en;
    logic                     active;
    logic                     mac_valid_reg;
    logic                     clear_reg;
    logic                     fire_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     done_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_next;
    logic signed [ACC_W:0]    sum_wide;

    assign active = CNT_W'(col_id) < cols_eff;
    assign wr_en  = tok_in.valid && tok_in.is_load && (SEL_W'(tok_in.col) == SEL_W'(col_id));

    // weight column of this cell
    wsmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_INNER)
    ) u_weights (
        .clk   (clk),
        .we    (wr_en),
        .waddr (K_W'(tok_in.k)),
        .wdata (tok_in.value),
        .raddr (K_W'(tok_in.k)),
        .rdata (weight)
    );

    // beat register, aligned with the weight read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    assign tok_out = tok_reg;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_valid_reg <= 1'b0;
            fire_reg      <= 1'b0;
        end
        else
        begin
            mac_valid_reg <= tok_reg.valid && !tok_reg.is_load && active;
            fire_reg      <= tok_reg.valid && !tok_reg.is_load && tok_reg.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        clear_reg <= tok_reg.clear;
        prod_reg  <= $signed(weight) * tok_reg.value;
    end

    // accumulate with saturation at the accumulator range
    always_comb
    begin
        if (clear_reg)
        begin
            sum_wide = (ACC_W + 1)'(prod_reg);
        end
        else
        begin
            sum_wide = (ACC_W + 1)'(sum_reg) + (ACC_W + 1)'(prod_reg);
        end
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_next = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fire_reg;
            if (mac_valid_reg)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    assign status.done = done_reg;
    assign status.sum  = sum_reg;

endmodule

/* design/wsmm_checker.sv */
// ----------------------------------------------------------------------------
// wsmm_checker
// Port-level checks of the multiplier's result stream, bound to the top.
// ----------------------------------------------------------------------------
module wsmm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [3:0]         out_col,
    input logic signed [31:0] out_value,
    input logic               out_saturated,
    input logic               out_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_col)
            && $stable(out_last) && $stable(out_saturated))
        else $error("result beat changed while stalled");

    // intake stays closed until the row's last result is staged
    a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input accepted during a row's results");

    // results of a row come back to back in column order
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid && out_col == 4'($past(out_col) + 4'd1))
        else $error("result column out of order");

    // a row's results start at column zero
    a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_col == 4'd0)
        else $error("row results do not start at column zero");

endmodule

bind weight_stationary_matmul_top wsmm_checker u_wsmm_checker (.*);
